// ===== rtl/core/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and constants for the RV32I instruction decoder pipeline.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int unsigned XLEN = 32;

  // major opcodes, bits 6:0
  localparam logic [6:0] OPC_LUI    = 7'd55;
  localparam logic [6:0] OPC_AUIPC  = 7'd23;
  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [6:0] OPC_JALR   = 7'd103;
  localparam logic [6:0] OPC_BRANCH = 7'd99;
  localparam logic [6:0] OPC_LOAD   = 7'd3;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_OPIMM  = 7'd19;
  localparam logic [6:0] OPC_OP     = 7'd51;

  // funct3 codes for OP and OP-IMM
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 codes for branches
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BEQX = 3'd2;
  localparam logic [2:0] F3_BNEX = 3'd3;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // funct3 codes for loads (unused codes fold onto neighbors)
  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LWX  = 3'd3;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_LHU  = 3'd5;
  localparam logic [2:0] F3_LBUX = 3'd6;
  localparam logic [2:0] F3_LHUX = 3'd7;

  typedef enum logic [3:0] {
    CLS_NONE,
    CLS_LUI,
    CLS_AUIPC,
    CLS_JAL,
    CLS_JALR,
    CLS_BRANCH,
    CLS_LOAD,
    CLS_STORE,
    CLS_OPIMM,
    CLS_OP
  } op_class_e;

  typedef enum logic [5:0] {
    MN_UNKNOWN = 6'd0,
    MN_LUI     = 6'd1,
    MN_AUIPC   = 6'd2,
    MN_JAL     = 6'd3,
    MN_JALR    = 6'd4,
    MN_BEQ     = 6'd5,
    MN_BNE     = 6'd6,
    MN_BLT     = 6'd7,
    MN_BGE     = 6'd8,
    MN_BLTU    = 6'd9,
    MN_BGEU    = 6'd10,
    MN_LB      = 6'd11,
    MN_LH      = 6'd12,
    MN_LW      = 6'd13,
    MN_LBU     = 6'd14,
    MN_LHU     = 6'd15,
    MN_SB      = 6'd16,
    MN_SH      = 6'd17,
    MN_SW      = 6'd18,
    MN_ADDI    = 6'd19,
    MN_SLTI    = 6'd20,
    MN_SLTIU   = 6'd21,
    MN_XORI    = 6'd22,
    MN_ORI     = 6'd23,
    MN_ANDI    = 6'd24,
    MN_SLLI    = 6'd25,
    MN_SRLI    = 6'd26,
    MN_SRAI    = 6'd27,
    MN_ADD     = 6'd28,
    MN_SUB     = 6'd29,
    MN_SLL     = 6'd30,
    MN_SLT     = 6'd31,
    MN_SLTU    = 6'd32,
    MN_XOR     = 6'd33,
    MN_SRL     = 6'd34,
    MN_SRA     = 6'd35,
    MN_OR      = 6'd36,
    MN_AND     = 6'd37
  } mnemonic_e;

  typedef enum logic [3:0] {
    FMT_NONE  = 4'd0,
    FMT_R     = 4'd1,
    FMT_I     = 4'd2,
    FMT_SHAMT = 4'd3,
    FMT_S     = 4'd4,
    FMT_LDJ   = 4'd5,
    FMT_B     = 4'd6,
    FMT_J     = 4'd7,
    FMT_U     = 4'd8
  } fmt_e;

  typedef enum logic [2:0] {
    IMM_ZERO,
    IMM_I,
    IMM_S,
    IMM_B,
    IMM_J,
    IMM_U,
    IMM_SHAMT
  } imm_sel_e;

  // stage 1 -> stage 2 payload
  typedef struct packed {
    logic [XLEN-1:0] word;
    op_class_e       cls;
  } s1_t;

  // stage 2 -> stage 3 payload
  typedef struct packed {
    logic [XLEN-1:0] word;
    mnemonic_e       mn;
    fmt_e            fmt;
    imm_sel_e        isel;
  } s2_t;

  // stage 3 payload, the finished result
  typedef struct packed {
    mnemonic_e         mn;
    fmt_e              fmt;
    logic [4:0]        rd;
    logic [4:0]        rs1;
    logic [4:0]        rs2;
    logic [XLEN-1:0]   imm;
  } s3_t;

endpackage

// ===== rtl/core/rv32i_instruction_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_core
// Three-stage pipelined RV32I instruction decoder.
// ----------------------------------------------------------------------------
// Decodes one 32-bit RV32I word per request into mnemonic code, operand
// format, rd/rs1/rs2 fields and the sign-extended immediate. A request passes
// three registers in order (opcode class, mnemonic select, immediate assembly);
// valid_o rises once it reaches the last, and the result is held there while
// stall_i is high. A new request is taken every cycle while stall_o is low.
// Each stage moves when its successor is empty or moving,
// so stall_o rises only once all three stages hold requests and stall_i is
// high; bubbles are squeezed out while the output waits.
module rv32i_instruction_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [31:0]        instruction_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [5:0]         mnemonic_o,
  output logic [3:0]         operand_format_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src_reg1_o,
  output logic [4:0]         src_reg2_o,
  output logic signed [31:0] immediate_o
);
  import rvdec_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;

  // stage advance chain
  assign en3     = !v3 || !stall_i;
  assign en2     = !v2 || en3;
  assign en1     = !v1 || en2;
  assign stall_o = !en1;

  // opcode class
  rvdec_class u_class (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (valid_i),
    .word_i  (instruction_i),
    .valid_o (v1),
    .data_o  (s1)
  );

  // mnemonic and format
  rvdec_mnem u_mnem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  // immediate and result register
  rvdec_imm u_imm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (s2),
    .valid_o (v3),
    .data_o  (s3)
  );

  // outputs
  assign valid_o          = v3;
  assign mnemonic_o       = s3.mn;
  assign operand_format_o = s3.fmt;
  assign dest_reg_o       = s3.rd;
  assign src_reg1_o       = s3.rs1;
  assign src_reg2_o       = s3.rs2;
  assign immediate_o      = s3.imm;

  // back pressure only with a full pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1 && v2 && v3 && stall_i))
    else $error("stall raised with room in the pipeline");

  // unknown words carry no format and no immediate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && mnemonic_o == MN_UNKNOWN) |->
      (operand_format_o == FMT_NONE && immediate_o == '0))
    else $error("unknown mnemonic with format or immediate");

  // register-register ops carry a zero immediate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && operand_format_o == FMT_R) |-> (immediate_o == '0))
    else $error("R format with nonzero immediate");

  // shift amounts stay within five bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && operand_format_o == FMT_SHAMT) |-> (immediate_o[31:5] == '0))
    else $error("shift amount wider than five bits");

endmodule

// ===== rtl/core/rvdec_class.sv =====
// ----------------------------------------------------------------------------
// rvdec_class
// Stage 1: classifies the major opcode and registers the word.
// ----------------------------------------------------------------------------
module rvdec_class (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [31:0]           word_i,
  output logic                  valid_o,
  output rvdec_pkg::s1_t        data_o
);
  import rvdec_pkg::*;

  logic      valid_q;
  s1_t       data_q;
  op_class_e cls_d;

  // opcode match
  always_comb begin
    case (word_i[6:0])
      OPC_LUI:    cls_d = CLS_LUI;
      OPC_AUIPC:  cls_d = CLS_AUIPC;
      OPC_JAL:    cls_d = CLS_JAL;
      OPC_JALR:   cls_d = CLS_JALR;
      OPC_BRANCH: cls_d = CLS_BRANCH;
      OPC_LOAD:   cls_d = CLS_LOAD;
      OPC_STORE:  cls_d = CLS_STORE;
      OPC_OPIMM:  cls_d = CLS_OPIMM;
      OPC_OP:     cls_d = CLS_OP;
      default:    cls_d = CLS_NONE;
    endcase
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q.word <= word_i;
      data_q.cls  <= cls_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/rvdec_mnem.sv =====
// ----------------------------------------------------------------------------
// rvdec_mnem
// Stage 2: picks mnemonic, operand format and immediate kind from class, funct3 and bit 30.
// ----------------------------------------------------------------------------
module rvdec_mnem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  rvdec_pkg::s1_t        data_i,
  output logic                  valid_o,
  output rvdec_pkg::s2_t        data_o
);
  import rvdec_pkg::*;

  logic       valid_q;
  s2_t        data_q;
  logic [2:0] f3;
  logic       b30;
  mnemonic_e  mn_d;
  fmt_e       fmt_d;
  imm_sel_e   isel_d;

  assign f3  = data_i.word[14:12];
  assign b30 = data_i.word[30];

  // mnemonic and format select
  always_comb begin
    mn_d   = MN_UNKNOWN;
    fmt_d  = FMT_NONE;
    isel_d = IMM_ZERO;
    case (data_i.cls)
      CLS_LUI: begin
        mn_d = MN_LUI; fmt_d = FMT_U; isel_d = IMM_U;
      end
      CLS_AUIPC: begin
        mn_d = MN_AUIPC; fmt_d = FMT_U; isel_d = IMM_U;
      end
      CLS_JAL: begin
        mn_d = MN_JAL; fmt_d = FMT_J; isel_d = IMM_J;
      end
      CLS_JALR: begin
        mn_d = MN_JALR; fmt_d = FMT_LDJ; isel_d = IMM_I;
      end
      CLS_BRANCH: begin
        fmt_d  = FMT_B;
        isel_d = IMM_B;
        case (f3)
          F3_BGEU:          mn_d = MN_BGEU;
          F3_BLTU:          mn_d = MN_BLTU;
          F3_BGE:           mn_d = MN_BGE;
          F3_BLT:           mn_d = MN_BLT;
          F3_BNE, F3_BNEX:  mn_d = MN_BNE;
          default:          mn_d = MN_BEQ;
        endcase
      end
      CLS_LOAD: begin
        fmt_d  = FMT_LDJ;
        isel_d = IMM_I;
        case (f3)
          F3_LHU, F3_LHUX:  mn_d = MN_LHU;
          F3_LBU, F3_LBUX:  mn_d = MN_LBU;
          F3_LW, F3_LWX:    mn_d = MN_LW;
          F3_LH:            mn_d = MN_LH;
          default:          mn_d = MN_LB;
        endcase
      end
      CLS_STORE: begin
        fmt_d  = FMT_S;
        isel_d = IMM_S;
        // width bits fold: bit 1 word, else bit 0 half, else byte
        if (f3[1]) begin
          mn_d = MN_SW;
        end else if (f3[0]) begin
          mn_d = MN_SH;
        end else begin
          mn_d = MN_SB;
        end
      end
      CLS_OPIMM: begin
        fmt_d  = FMT_I;
        isel_d = IMM_I;
        case (f3)
          F3_ADD:  mn_d = MN_ADDI;
          F3_SLL: begin
            mn_d = MN_SLLI; fmt_d = FMT_SHAMT; isel_d = IMM_SHAMT;
          end
          F3_SLT:  mn_d = MN_SLTI;
          F3_SLTU: mn_d = MN_SLTIU;
          F3_XOR:  mn_d = MN_XORI;
          F3_SR: begin
            mn_d   = b30 ? MN_SRAI : MN_SRLI;
            fmt_d  = FMT_SHAMT;
            isel_d = IMM_SHAMT;
          end
          F3_OR:   mn_d = MN_ORI;
          default: mn_d = MN_ANDI;
        endcase
      end
      CLS_OP: begin
        fmt_d  = FMT_R;
        isel_d = IMM_ZERO;
        case (f3)
          F3_ADD:  mn_d = b30 ? MN_SUB : MN_ADD;
          F3_SLL:  mn_d = MN_SLL;
          F3_SLT:  mn_d = MN_SLT;
          F3_SLTU: mn_d = MN_SLTU;
          F3_XOR:  mn_d = MN_XOR;
          F3_SR:   mn_d = b30 ? MN_SRA : MN_SRL;
          F3_OR:   mn_d = MN_OR;
          default: mn_d = MN_AND;
        endcase
      end
      default: begin
        mn_d   = MN_UNKNOWN;
        fmt_d  = FMT_NONE;
        isel_d = IMM_ZERO;
      end
    endcase
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q.word <= data_i.word;
      data_q.mn   <= mn_d;
      data_q.fmt  <= fmt_d;
      data_q.isel <= isel_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/rvdec_imm.sv =====
// ----------------------------------------------------------------------------
// rvdec_imm
// Stage 3: assembles the immediate and holds the finished result.
// ----------------------------------------------------------------------------
module rvdec_imm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  rvdec_pkg::s2_t        data_i,
  output logic                  valid_o,
  output rvdec_pkg::s3_t        data_o
);
  import rvdec_pkg::*;

  logic            valid_q;
  s3_t             data_q;
  logic [XLEN-1:0] w;
  logic [XLEN-1:0] imm_d;

  assign w = data_i.word;

  // immediate assembly per format
  always_comb begin
    case (data_i.isel)
      IMM_I:     imm_d = {{20{w[31]}}, w[31:20]};
      IMM_S:     imm_d = {{20{w[31]}}, w[31:25], w[11:7]};
      IMM_B:     imm_d = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      IMM_J:     imm_d = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      IMM_U:     imm_d = {w[31:12], 12'd0};
      IMM_SHAMT: imm_d = {27'd0, w[24:20]};
      default:   imm_d = '0;
    endcase
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q.mn  <= data_i.mn;
      data_q.fmt <= data_i.fmt;
      data_q.rd  <= w[11:7];
      data_q.rs1 <= w[19:15];
      data_q.rs2 <= w[24:20];
      data_q.imm <= imm_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sim/tb_rv32i_instruction_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_decoder_core
// Self-checking bench for the pipelined RV32I instruction decoder.
// ----------------------------------------------------------------------------
// A queue of instruction words is filled up front: a short directed set
// (word extremes, every major opcode, funct3 folding, bit-30 variants),
// then random words, most of them with a legal major opcode. A clocked
// driver offers them with random gaps and a clocked monitor takes the
// results with random stalls. Each accepted request is decoded by a local
// predictor, and the results are compared in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder_core;
  import rvdec_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned MAX_WAIT     = 14;

  typedef struct {
    logic [31:0] word;
    s3_t         dec;
  } decoded_req_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                valid_i       = 1'b0;
  logic                stall_o;
  logic [31:0]         instruction_i = '0;
  logic                valid_o;
  logic                stall_i       = 1'b0;
  logic [5:0]          mnemonic_o;
  logic [3:0]          operand_format_o;
  logic [4:0]          dest_reg_o;
  logic [4:0]          src_reg1_o;
  logic [4:0]          src_reg2_o;
  logic signed [31:0]  immediate_o;

  logic [31:0]         word_q[$];
  decoded_req_t        decoded_q[$];

  int unsigned         cycle_cnt    = 0;
  int unsigned         mismatch_cnt = 0;
  int unsigned         sent_cnt     = 0;
  int unsigned         taken_cnt    = 0;
  int unsigned         gap_left     = 0;
  int unsigned         hold_left    = 0;
  int unsigned         src_draw;
  int unsigned         sink_draw;
  logic                src_eager    = 1'b0;
  logic                sink_eager   = 1'b0;
  decoded_req_t        want;
  s3_t                 got;

  logic [6:0] major_ops [9] = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH,
                                OPC_LOAD, OPC_STORE, OPC_OPIMM, OPC_OP};

  rv32i_instruction_decoder_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .instruction_i    (instruction_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .mnemonic_o       (mnemonic_o),
    .operand_format_o (operand_format_o),
    .dest_reg_o       (dest_reg_o),
    .src_reg1_o       (src_reg1_o),
    .src_reg2_o       (src_reg2_o),
    .immediate_o      (immediate_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted decode of one word
  function automatic s3_t decode_word(logic [31:0] w);
    s3_t        d;
    logic [2:0] f3;
    f3    = w[14:12];
    d.mn  = MN_UNKNOWN;
    d.fmt = FMT_NONE;
    d.rd  = w[11:7];
    d.rs1 = w[19:15];
    d.rs2 = w[24:20];
    d.imm = '0;
    case (w[6:0])
      OPC_LUI, OPC_AUIPC: begin
        d.mn  = (w[6:0] == OPC_LUI) ? MN_LUI : MN_AUIPC;
        d.fmt = FMT_U;
        d.imm = {w[31:12], 12'h000};
      end
      OPC_JAL: begin
        d.mn  = MN_JAL;
        d.fmt = FMT_J;
        d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        d.mn  = MN_JALR;
        d.fmt = FMT_LDJ;
        d.imm = {{20{w[31]}}, w[31:20]};
      end
      OPC_BRANCH: begin
        // unused codes 2 and 3 fold onto beq and bne
        case (f3)
          F3_BEQ, F3_BEQX: d.mn = MN_BEQ;
          F3_BNE, F3_BNEX: d.mn = MN_BNE;
          F3_BLT:          d.mn = MN_BLT;
          F3_BGE:          d.mn = MN_BGE;
          F3_BLTU:         d.mn = MN_BLTU;
          default:         d.mn = MN_BGEU;
        endcase
        d.fmt = FMT_B;
        d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_LOAD: begin
        case (f3)
          F3_LB:           d.mn = MN_LB;
          F3_LH:           d.mn = MN_LH;
          F3_LW, F3_LWX:   d.mn = MN_LW;
          F3_LBU, F3_LBUX: d.mn = MN_LBU;
          default:         d.mn = MN_LHU;
        endcase
        d.fmt = FMT_LDJ;
        d.imm = {{20{w[31]}}, w[31:20]};
      end
      OPC_STORE: begin
        // width bit 1 wins, then bit 0
        d.mn  = w[13] ? MN_SW : (w[12] ? MN_SH : MN_SB);
        d.fmt = FMT_S;
        d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_OPIMM: begin
        d.fmt = FMT_I;
        d.imm = {{20{w[31]}}, w[31:20]};
        case (f3)
          F3_ADD:  d.mn = MN_ADDI;
          F3_SLL:  d.mn = MN_SLLI;
          F3_SLT:  d.mn = MN_SLTI;
          F3_SLTU: d.mn = MN_SLTIU;
          F3_XOR:  d.mn = MN_XORI;
          F3_SR:   d.mn = w[30] ? MN_SRAI : MN_SRLI;
          F3_OR:   d.mn = MN_ORI;
          default: d.mn = MN_ANDI;
        endcase
        // shift forms carry only the shamt
        if (f3 == F3_SLL || f3 == F3_SR) begin
          d.fmt = FMT_SHAMT;
          d.imm = {27'd0, w[24:20]};
        end
      end
      OPC_OP: begin
        d.fmt = FMT_R;
        case (f3)
          F3_ADD:  d.mn = w[30] ? MN_SUB : MN_ADD;
          F3_SLL:  d.mn = MN_SLL;
          F3_SLT:  d.mn = MN_SLT;
          F3_SLTU: d.mn = MN_SLTU;
          F3_XOR:  d.mn = MN_XOR;
          F3_SR:   d.mn = w[30] ? MN_SRA : MN_SRL;
          F3_OR:   d.mn = MN_OR;
          default: d.mn = MN_AND;
        endcase
      end
      default: ;
    endcase
    return d;
  endfunction

  // random word, mostly with a legal major opcode
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 99) < 85) begin
      w[6:0] = major_ops[$urandom_range(0, 8)];
    end
    return w;
  endfunction

  // wait count for one request; eager phases never wait
  function automatic int unsigned pick_wait(logic eager);
    return eager ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // stimulus and end of run
  initial begin
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'hFFFF_FFFF);
    foreach (major_ops[i]) begin
      word_q.push_back({25'd0, major_ops[i]});
      word_q.push_back({25'h1FF_FFFF, major_ops[i]});
    end
    word_q.push_back({17'h08000, F3_ADD, 5'd3, OPC_OP});
    word_q.push_back({17'h08000, F3_SR, 5'd3, OPC_OP});
    word_q.push_back({17'h0803E, F3_SR, 5'd1, OPC_OPIMM});
    word_q.push_back({17'h0803E, F3_SLL, 5'd1, OPC_OPIMM});
    word_q.push_back({17'h1FFFF, F3_BEQX, 5'd0, OPC_BRANCH});
    word_q.push_back({17'h00000, F3_BNEX, 5'd31, OPC_BRANCH});
    word_q.push_back({17'h0F0F0, F3_LBUX, 5'd9, OPC_LOAD});
    repeat (RANDOM_WORDS) word_q.push_back(random_word());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        decoded_q.push_back('{word: instruction_i, dec: decode_word(instruction_i)});
        sent_cnt = sent_cnt + 1;
        if (sent_cnt % 128 == 0) src_eager = ($urandom_range(0, 3) == 0);
        src_draw = pick_wait(src_eager);
        if (src_draw == 0 && word_q.size() != 0) begin
          instruction_i <= word_q.pop_front();
        end else begin
          valid_i  <= 1'b0;
          gap_left <= (src_draw == 0) ? 0 : src_draw - 1;
        end
      end else if (!valid_i) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (word_q.size() != 0) begin
          instruction_i <= word_q.pop_front();
          valid_i       <= 1'b1;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        got = '{mn: mnemonic_e'(mnemonic_o), fmt: fmt_e'(operand_format_o),
                rd: dest_reg_o, rs1: src_reg1_o, rs2: src_reg2_o, imm: immediate_o};
        if (decoded_q.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result mn=%0d fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                     got.mn, got.fmt, got.rd, got.rs1, got.rs2, got.imm);
        end else begin
          want = decoded_q.pop_front();
          if (got.mn !== want.dec.mn || got.fmt !== want.dec.fmt ||
              got.rd !== want.dec.rd || got.rs1 !== want.dec.rs1 ||
              got.rs2 !== want.dec.rs2 || got.imm !== want.dec.imm) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("mismatch on word %h", want.word);
              $display("  expected mn=%0d fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                       want.dec.mn, want.dec.fmt, want.dec.rd, want.dec.rs1,
                       want.dec.rs2, want.dec.imm);
              $display("  actual   mn=%0d fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                       got.mn, got.fmt, got.rd, got.rs1, got.rs2, got.imm);
            end
          end
        end
        taken_cnt = taken_cnt + 1;
        if (taken_cnt % 128 == 0) sink_eager = ($urandom_range(0, 3) == 0);
        sink_draw = pick_wait(sink_eager);
        stall_i   <= (sink_draw != 0);
        hold_left <= sink_draw;
      end else if (valid_o && hold_left != 0) begin
        // stall counts down only against a waiting result
        hold_left <= hold_left - 1;
        stall_i   <= (hold_left > 1);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

endmodule
